@@ rtl/core/csvt_pkg.sv @@
`timescale 1ns / 1ps

package csvt_pkg;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_FIELD = 2'd1,
        KIND_ROW   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        MODE_UNQ    = 2'd0,
        MODE_QUOTED = 2'd1,
        MODE_PEND   = 2'd2
    } mode_t;

    typedef struct packed {
        mode_t       mode;
        logic        swallow;
        logic        field_open;
        logic [7:0]  col;
        logic [15:0] row;
        logic [8:0]  maxc;
    } parse_state_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        logic [15:0] row;
        logic [7:0]  col;
        logic [8:0]  widest;
        logic        run_end;
    } token_t;

    // Handshake between the output queue and the top level.
    typedef struct packed {
        logic ready;
        logic valid;
    } queue_status_t;

endpackage

@@ rtl/core/csvt_decode.sv @@
`timescale 1ns / 1ps

module csvt_decode
    import csvt_pkg::*;
#(
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_ROWS    = 65536
)
(
    input  parse_state_t cur,
    input  logic [7:0]   in_byte,
    input  logic         in_last,
    output parse_state_t nxt,
    output logic [1:0]   count,
    output token_t       tok0,
    output token_t       tok1
);

    localparam int COL_CAP  = (MAX_COLUMNS - 1 > 255) ? 255 : MAX_COLUMNS - 1;
    localparam int ROW_CAP  = (MAX_ROWS - 1 > 65535) ? 65535 : MAX_ROWS - 1;
    localparam int WIDE_CAP = (MAX_COLUMNS > 511) ? 511 : MAX_COLUMNS;

    localparam logic [7:0]  COL_CAP_V  = 8'(COL_CAP);
    localparam logic [15:0] ROW_CAP_V  = 16'(ROW_CAP);
    localparam logic [8:0]  WIDE_CAP_V = 9'(WIDE_CAP);

    always_comb
    begin
        parse_state_t s;
        token_t       res [2];
        logic [1:0]   n;
        logic         crlf;
        logic         swallowed;
        logic         do_unq;
        logic [8:0]   fields;

        s         = cur;
        res[0]    = '0;
        res[1]    = '0;
        n         = 2'd0;
        crlf      = (in_byte == CH_CR) || (in_byte == CH_LF);
        swallowed = 1'b0;
        do_unq    = 1'b0;
        fields    = 9'd0;

        if (s.swallow)
        begin
            s.swallow = 1'b0;
            swallowed = crlf;
        end

        if (!swallowed)
        begin
            case (s.mode)
                MODE_QUOTED:
                begin
                    if (in_byte == CH_QUOTE)
                    begin
                        s.mode = MODE_PEND;
                    end
                    else
                    begin
                        res[n[0]] = '{KIND_DATA, in_byte, s.row, s.col, s.maxc, 1'b0};
                        n = n + 2'd1;
                    end
                end
                MODE_PEND:
                begin
                    if (in_byte == CH_QUOTE)
                    begin
                        s.mode = MODE_QUOTED;
                        res[n[0]] = '{KIND_DATA, in_byte, s.row, s.col, s.maxc, 1'b0};
                        n = n + 2'd1;
                    end
                    else if (in_byte == CH_COMMA)
                    begin
                        s.mode = MODE_UNQ;
                        res[n[0]] = '{KIND_FIELD, 8'd0, s.row, s.col, s.maxc, 1'b0};
                        n = n + 2'd1;
                        if (s.col < COL_CAP_V)
                            s.col = s.col + 8'd1;
                        s.field_open = 1'b0;
                    end
                    else
                    begin
                        do_unq = 1'b1;
                    end
                end
                default:
                begin
                    do_unq = 1'b1;
                end
            endcase

            if (do_unq)
            begin
                s.mode = MODE_UNQ;
                if (in_byte == CH_QUOTE)
                begin
                    s.mode       = MODE_QUOTED;
                    s.field_open = 1'b1;
                end
                else if (crlf)
                begin
                    fields = {1'b0, s.col} + 9'd1;
                    if (fields > WIDE_CAP_V)
                        fields = WIDE_CAP_V;
                    if (fields > s.maxc)
                        s.maxc = fields;
                    res[n[0]] = '{KIND_ROW, 8'd0, s.row, s.col, s.maxc, 1'b0};
                    n = n + 2'd1;
                    if (s.row < ROW_CAP_V)
                        s.row = s.row + 16'd1;
                    s.col        = 8'd0;
                    s.field_open = 1'b0;
                    s.swallow    = 1'b1;
                end
                else if (in_byte == CH_COMMA)
                begin
                    res[n[0]] = '{KIND_FIELD, 8'd0, s.row, s.col, s.maxc, 1'b0};
                    n = n + 2'd1;
                    if (s.col < COL_CAP_V)
                        s.col = s.col + 8'd1;
                    s.field_open = 1'b0;
                end
                else
                begin
                    s.field_open = 1'b1;
                    res[n[0]] = '{KIND_DATA, in_byte, s.row, s.col, s.maxc, 1'b0};
                    n = n + 2'd1;
                end
            end
        end

        // Close a dangling field at the end of the buffer.
        if (in_last)
        begin
            if (s.field_open || (s.mode == MODE_QUOTED) || (s.mode == MODE_PEND))
            begin
                res[n[0]] = '{KIND_FIELD, 8'd0, s.row, s.col, s.maxc, 1'b0};
                n = n + 2'd1;
                if (s.col < COL_CAP_V)
                    s.col = s.col + 8'd1;
            end
            s.mode       = MODE_UNQ;
            s.swallow    = 1'b0;
            s.field_open = 1'b0;
        end

        if (n == 2'd1)
            res[0].run_end = 1'b1;
        else if (n == 2'd2)
            res[1].run_end = 1'b1;

        nxt   = s;
        count = n;
        tok0  = res[0];
        tok1  = res[1];
    end

endmodule

@@ rtl/core/csvt_out_queue.sv @@
`timescale 1ns / 1ps

module csvt_out_queue
    import csvt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [1:0]    push_count,
    input  token_t        push_tok0,
    input  token_t        push_tok1,
    input  logic          out_stall,
    output queue_status_t status,
    output token_t        head
);

    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    token_t     slot0_reg;
    token_t     slot0_next;
    token_t     slot1_reg;
    token_t     slot1_next;
    logic       take;

    assign take         = (fill_reg != 2'd0) && !out_stall;
    assign status.valid = (fill_reg != 2'd0);
    // Take a new byte only when its results can land in an emptied queue.
    assign status.ready = (fill_reg == 2'd0) || ((fill_reg == 2'd1) && take);
    assign head         = slot0_reg;

    always_comb
    begin
        fill_next  = fill_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (push)
        begin
            fill_next  = push_count;
            slot0_next = push_tok0;
            slot1_next = push_tok1;
        end
        else if (take)
        begin
            fill_next  = fill_reg - 2'd1;
            slot0_next = slot1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= 2'd0;
        else
            fill_reg <= fill_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

@@ rtl/core/csv_field_tokenizer_core.sv @@
`timescale 1ns / 1ps

// CSV field tokenizer.
// Input channel: one beat carries one raw text byte (in_byte) and in_last,
// which marks the final byte of a buffer; a beat is taken when in_valid is
// high and in_stall is low.
// Output channel: one beat carries one token: a data byte, an end-of-field
// mark or an end-of-row mark, tagged with row_index, column_index and the
// widest finished row so far; run_end flags the last token of a byte.
// The tokens of a byte appear on the output in the cycle after the byte
// is taken. Throughput: one byte per cycle while each byte yields at most
// one token and out_stall is low; a byte that yields two tokens (a field
// closed by in_last) holds the input back, since the two-entry output
// queue drains one token per beat. A byte with no token is still taken.
// Reset clears the parser state, the row and column counters and the queue.
// When the receiver stalls, the queue head holds and in_stall rises as soon
// as the queue cannot take the next byte's tokens.
// Row and column counters carry across buffers and saturate.
module csv_field_tokenizer_core
    import csvt_pkg::*;
#(
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_ROWS    = 65536
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  data_byte,
    output logic [15:0] row_index,
    output logic [7:0]  column_index,
    output logic [8:0]  widest_row,
    output logic        run_end
);

    parse_state_t  state_reg;
    parse_state_t  state_next;
    logic [1:0]    tok_count;
    token_t        tok0;
    token_t        tok1;
    token_t        head;
    queue_status_t q_status;
    logic          in_acc;

    assign in_stall = !q_status.ready;
    assign in_acc   = in_valid && !in_stall;

    // Work out the tokens and the next parser state for the byte on the port.
    csvt_decode #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_decode (
        .cur     (state_reg),
        .in_byte (in_byte),
        .in_last (in_last),
        .nxt     (state_next),
        .count   (tok_count),
        .tok0    (tok0),
        .tok1    (tok1)
    );

    // Hold the tokens until the receiver takes them.
    csvt_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_acc),
        .push_count (tok_count),
        .push_tok0  (tok0),
        .push_tok1  (tok1),
        .out_stall  (out_stall),
        .status     (q_status),
        .head       (head)
    );

    // Advance the parser state only on an accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{MODE_UNQ, 1'b0, 1'b0, 8'd0, 16'd0, 9'd0};
        end
        else if (in_acc)
        begin
            state_reg <= state_next;
        end
    end

    assign out_valid    = q_status.valid;
    assign kind         = head.kind;
    assign data_byte    = head.data;
    assign row_index    = head.row;
    assign column_index = head.col;
    assign widest_row   = head.widest;
    assign run_end      = head.run_end;

    // A stalled input means tokens are waiting on the output.
    a_stall_has_tokens: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with an empty output queue");

    // The end of a buffer leaves the parser unquoted with no open field.
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && in_last |=> (state_reg.mode == MODE_UNQ) && !state_reg.field_open
            && !state_reg.swallow)
        else $error("parser state not cleared after final byte");

    // Marks carry no character.
    a_mark_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != KIND_DATA) |-> (data_byte == 8'd0))
        else $error("end mark carries nonzero data");

    // The widest row never shrinks across accepted beats.
    a_widest_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg.maxc >= $past(state_reg.maxc)))
        else $error("widest row decreased");

endmodule

@@ verif/tb_csv_field_tokenizer_core.sv @@
`timescale 1ns / 1ps

module tb_csv_field_tokenizer_core;
    import csvt_pkg::*;

    localparam int MAX_COLUMNS = 256;
    localparam int MAX_ROWS    = 65536;

    // Saturation points of the parser counters.
    localparam int COL_CAP  = (MAX_COLUMNS - 1 > 255) ? 255 : MAX_COLUMNS - 1;
    localparam int ROW_CAP  = (MAX_ROWS - 1 > 65535) ? 65535 : MAX_ROWS - 1;
    localparam int WIDE_CAP = (MAX_COLUMNS > 511) ? 511 : MAX_COLUMNS;

    // Cycles without any beat on either side before the run is declared hung.
    // The longest legal quiet stretch is the receiver hold-off plus one long
    // sender gap, well under this.
    localparam int IDLE_LIMIT    = 4000;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_TRIGGER  = 200;
    localparam int DRAIN_CYCLES  = 20;

    // One queued input beat; no_gap suppresses sender idling after it.
    typedef struct packed {
        logic [7:0] b;
        logic       last;
        logic       no_gap;
    } text_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte = 8'h00;
    logic        in_last = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] row_index;
    logic [7:0]  column_index;
    logic [8:0]  widest_row;
    logic        run_end;

    csv_field_tokenizer_core #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .in_last      (in_last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .data_byte    (data_byte),
        .row_index    (row_index),
        .column_index (column_index),
        .widest_row   (widest_row),
        .run_end      (run_end)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    text_beat_t text_q[$];
    token_t     token_q[$];
    int         queued_bytes = 0;
    int         error_count = 0;

    // ------------------------------------------------------------------
    // Tokenizer shadow state and the per-byte token predictor.
    // ------------------------------------------------------------------
    mode_t       sh_mode = MODE_UNQ;
    logic        sh_swallow = 1'b0;
    logic        sh_open = 1'b0;
    logic [7:0]  sh_col = 8'd0;
    logic [15:0] sh_row = 16'd0;
    logic [8:0]  sh_widest = 9'd0;

    // Tokens produced by the byte being predicted (at most two).
    token_t      burst[2];
    int          burst_n;

    task automatic emit_token(input kind_t k, input logic [7:0] d);
        token_t t;
        t.kind    = k;
        t.data    = d;
        t.row     = sh_row;
        t.col     = sh_col;
        t.widest  = sh_widest;
        t.run_end = 1'b0;
        burst[burst_n] = t;
        burst_n++;
    endtask

    task automatic close_field();
        emit_token(KIND_FIELD, 8'h00);
        if (sh_col < COL_CAP)
            sh_col = sh_col + 8'd1;
        sh_open = 1'b0;
    endtask

    // Unquoted handling; also reached when a pending quote meets a byte
    // that is neither a quote nor a comma.
    task automatic plain_byte(input logic [7:0] b);
        logic [8:0] fields;
        sh_mode = MODE_UNQ;
        if (b == CH_QUOTE)
        begin
            sh_mode = MODE_QUOTED;
            sh_open = 1'b1;
        end
        else if (b == CH_CR || b == CH_LF)
        begin
            // Update the widest row before tagging the row mark with it.
            fields = {1'b0, sh_col} + 9'd1;
            if (fields > WIDE_CAP)
                fields = 9'(WIDE_CAP);
            if (fields > sh_widest)
                sh_widest = fields;
            emit_token(KIND_ROW, 8'h00);
            if (sh_row < ROW_CAP)
                sh_row = sh_row + 16'd1;
            sh_col     = 8'd0;
            sh_open    = 1'b0;
            sh_swallow = 1'b1;
        end
        else if (b == CH_COMMA)
        begin
            close_field();
        end
        else
        begin
            sh_open = 1'b1;
            emit_token(KIND_DATA, b);
        end
    endtask

    task automatic predict_tokens(input logic [7:0] b, input logic last);
        logic swallowed;
        swallowed = 1'b0;
        burst_n   = 0;
        // Drop one CR or LF right after a row end.
        if (sh_swallow)
        begin
            sh_swallow = 1'b0;
            if (b == CH_CR || b == CH_LF)
                swallowed = 1'b1;
        end
        if (!swallowed)
        begin
            case (sh_mode)
                MODE_QUOTED:
                begin
                    if (b == CH_QUOTE)
                        sh_mode = MODE_PEND;
                    else
                        emit_token(KIND_DATA, b);
                end
                MODE_PEND:
                begin
                    if (b == CH_QUOTE)
                    begin
                        sh_mode = MODE_QUOTED;
                        emit_token(KIND_DATA, b);
                    end
                    else if (b == CH_COMMA)
                    begin
                        sh_mode = MODE_UNQ;
                        close_field();
                    end
                    else
                    begin
                        plain_byte(b);
                    end
                end
                default:
                    plain_byte(b);
            endcase
        end
        // Close whatever the buffer leaves open; counters carry over.
        if (last)
        begin
            if (sh_open || sh_mode == MODE_QUOTED || sh_mode == MODE_PEND)
                close_field();
            sh_mode    = MODE_UNQ;
            sh_swallow = 1'b0;
            sh_open    = 1'b0;
        end
        if (burst_n > 0)
            burst[burst_n - 1].run_end = 1'b1;
        for (int i = 0; i < burst_n; i++)
            token_q.push_back(burst[i]);
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b, input logic last, input logic no_gap);
        text_beat_t t;
        t.b      = b;
        t.last   = last;
        t.no_gap = no_gap;
        text_q.push_back(t);
        queued_bytes++;
    endtask

    // Queue a string; the final character carries the buffer-end flag.
    task automatic push_text(input string s, input logic last_at_end);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], last_at_end && (i == s.len() - 1), 1'b0);
    endtask

    // Any byte that carries no meaning outside quotes.
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_QUOTE || c == CH_COMMA || c == CH_CR || c == CH_LF);
        return c;
    endfunction

    // Idle length: mostly none, often short, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Build one CSV record (or a burst of noise) and queue it.
    task automatic push_record();
        logic [7:0] rec[$];
        logic [7:0] c;
        logic       last_flag;
        logic       no_gap;
        int         nfields;
        int         style;
        int         len;
        int         r;
        no_gap    = ($urandom_range(0, 4) == 0);
        last_flag = 1'b0;
        if ($urandom_range(0, 9) == 0)
        begin
            // Noise: arbitrary bytes with an arbitrary buffer end.
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
                rec.push_back(8'($urandom_range(0, 255)));
            last_flag = ($urandom_range(0, 9) == 0);
        end
        else
        begin
            nfields = $urandom_range(1, 6);
            for (int f = 0; f < nfields; f++)
            begin
                if (f > 0)
                    rec.push_back(CH_COMMA);
                style = $urandom_range(0, 9);
                if (style >= 1 && style <= 5)
                begin
                    len = $urandom_range(1, 4);
                    for (int i = 0; i < len; i++)
                        rec.push_back(plain_char());
                end
                else if (style >= 6)
                begin
                    rec.push_back(CH_QUOTE);
                    len = $urandom_range(0, 4);
                    for (int i = 0; i < len; i++)
                    begin
                        r = $urandom_range(0, 19);
                        if (r < 3)
                        begin
                            rec.push_back(CH_QUOTE);
                            rec.push_back(CH_QUOTE);
                        end
                        else if (r < 5)
                            rec.push_back(CH_COMMA);
                        else if (r < 7)
                            rec.push_back(r[0] ? CH_CR : CH_LF);
                        else
                        begin
                            do
                                c = 8'($urandom_range(0, 255));
                            while (c == CH_QUOTE);
                            rec.push_back(c);
                        end
                    end
                    rec.push_back(CH_QUOTE);
                    // Broken close: a quote followed by some other byte.
                    if (style == 9)
                        rec.push_back(plain_char());
                end
            end
            r = $urandom_range(0, 9);
            case (r)
                0, 1, 2:
                    rec.push_back(CH_LF);
                3, 4:
                    rec.push_back(CH_CR);
                5, 6:
                begin
                    rec.push_back(CH_CR);
                    rec.push_back(CH_LF);
                end
                7:
                begin
                    rec.push_back(CH_LF);
                    rec.push_back(CH_LF);
                end
                default:
                    ;
            endcase
            last_flag = (r > 7) || ($urandom_range(0, 7) == 0);
        end
        for (int i = 0; i < rec.size(); i++)
            push_byte(rec[i], last_flag && (i == rec.size() - 1), no_gap);
    endtask

    task automatic note_mismatch(input string msg);
        $display("mismatch: %s", msg);
        error_count++;
    endtask

    task automatic check_field(input int idx, input string name,
                               input logic [31:0] got, input logic [31:0] want);
        if (got !== want)
            note_mismatch($sformatf("token %0d %s got %0h want %0h", idx, name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Driver: offer queued bytes, predict on every accepted beat.
    // ------------------------------------------------------------------
    int         tx_gap = 0;
    text_beat_t tx_next;
    logic       tx_valid_nx;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            tx_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_tokens(in_byte, in_last);
            // Hold a stalled beat; otherwise idle out the gap or advance.
            if (!in_valid || !in_stall)
            begin
                tx_valid_nx = 1'b0;
                if (tx_gap > 0)
                    tx_gap--;
                else if (text_q.size() > 0)
                begin
                    tx_next = text_q.pop_front();
                    in_byte <= tx_next.b;
                    in_last <= tx_next.last;
                    tx_valid_nx = 1'b1;
                    tx_gap = tx_next.no_gap ? 0 : idle_len();
                end
                in_valid <= tx_valid_nx;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each accepted token with the oldest prediction and
    // drive the receiver stall, including one long hold-off that lets the
    // block fill up while the sender keeps offering.
    // ------------------------------------------------------------------
    token_t tok_want;
    int     tokens_seen = 0;
    int     rx_wait = 0;
    int     hold_left = 0;
    logic   hold_done = 1'b0;
    logic   rx_calm = 1'b0;
    logic   rx_stall_nx;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (token_q.size() == 0)
                    note_mismatch($sformatf("token %0d arrived with none pending (kind %0d)",
                                            tokens_seen, kind));
                else
                begin
                    tok_want = token_q.pop_front();
                    check_field(tokens_seen, "kind", 32'(kind), 32'(tok_want.kind));
                    check_field(tokens_seen, "data_byte", 32'(data_byte),
                                32'(tok_want.data));
                    check_field(tokens_seen, "row_index", 32'(row_index),
                                32'(tok_want.row));
                    check_field(tokens_seen, "column_index", 32'(column_index),
                                32'(tok_want.col));
                    check_field(tokens_seen, "widest_row", 32'(widest_row),
                                32'(tok_want.widest));
                    check_field(tokens_seen, "run_end", 32'(run_end),
                                32'(tok_want.run_end));
                end
                tokens_seen++;
            end

            if (!hold_done && tokens_seen >= HOLD_TRIGGER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            // Flip between stall-free stretches and choppy ones now and then.
            if ($urandom_range(0, 255) == 0)
                rx_calm = !rx_calm;

            rx_stall_nx = 1'b0;
            if (hold_left > 0)
            begin
                hold_left--;
                rx_stall_nx = 1'b1;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                rx_stall_nx = 1'b1;
            end
            else if (!rx_calm && $urandom_range(0, 5) == 0)
                rx_wait = idle_len();
            out_stall <= rx_stall_nx;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if neither side moves a beat for too long.
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("timeout after %0d quiet cycles", quiet_cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial
    begin
        // Directed: plain fields and a row end.
        push_text("a,b\n", 1'b0);
        // CR LF: the LF is swallowed.
        push_text("x\015\n", 1'b0);
        // Quoted field with a doubled quote, closed by quote-comma, CR row end.
        push_text("\"p\"\"q\",z\015", 1'b0);
        // Swallowed LF after the CR above.
        push_text("\n", 1'b0);
        // Closing quote followed by a plain byte, then LF.
        push_text("\"m\"k\n", 1'b0);
        // Empty quoted field closed by a quote then CR.
        push_text("\"\"\015", 1'b0);
        // Byte extremes; the buffer ends inside an open field.
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b1, 1'b0);
        // Buffer ends inside an open quote.
        push_text("\"o", 1'b1);
        // Buffer ends on a comma: nothing left open.
        push_text(",", 1'b1);
        // Buffer ends on a row end.
        push_text("\n", 1'b1);
        // Buffer ends right after an opening quote.
        push_text("\"", 1'b1);
        // Buffer ends on a pending quote.
        push_text("\"r\"", 1'b1);

        // A row wide enough to saturate the column count and widest row.
        for (int i = 0; i < MAX_COLUMNS + 44; i++)
            push_byte(CH_COMMA, 1'b0, 1'b1);
        push_byte("q", 1'b0, 1'b1);
        push_byte(CH_LF, 1'b0, 1'b1);

        while (queued_bytes < 560)
            push_record();

        for (int i = 0; i < 20; i++)
            push_record();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Let every byte go in, every token come out, then drain a little more.
        while (text_q.size() != 0 || in_valid)
            @(posedge clk);
        while (token_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
